### rtl/ctok_pkg.sv
// Shared types, constants and helper functions for the tokenizer.
// Used by ctok_scan and c_like_tokenizer; depends on nothing else.
`default_nettype none

package ctok_pkg;

	// Scanner modes.
	typedef enum logic [4:0] {
		M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_IDENT, M_INT, M_DOT, M_FRAC,
		M_EXPSTART, M_EXPSIGN, M_EXP, M_STR, M_ESC, M_HEX1, M_HEX2,
		M_BANG, M_EQUAL, M_LESS, M_GREATER, M_AMP, M_BAR
	} mode_t;

	// Record types.
	typedef enum logic [1:0] {
		REC_TOKEN = 2'd0,
		REC_TEXT  = 2'd1,
		REC_ERROR = 2'd2
	} rtype_t;

	// Token kinds.
	typedef enum logic [5:0] {
		K_END, K_IDENT, K_INT, K_REAL, K_STRING,
		K_AUTO, K_CIN, K_COUT, K_DOUBLE, K_ELSE, K_FOR, K_IF, K_KWINT,
		K_RETURN, K_KWSTRING, K_WHILE, K_DO, K_TRY, K_CATCH, K_THROW,
		K_PLUS, K_MINUS, K_STAR, K_SLASH, K_PERCENT, K_SEMI, K_COMMA,
		K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_NOT, K_NE, K_ASSIGN,
		K_EQ, K_LT, K_LE, K_SHL, K_GT, K_GE, K_SHR, K_ANDAND, K_OROR
	} kind_t;

	localparam int NumKw = 15;
	localparam int HoldDepth = 6;
	localparam int MaxRes = 8;
	localparam logic [30:0] IntMax = 31'h7FFF_FFFF;

	// Keywords, padded with spaces; the first letter sits in the top byte.
	localparam logic [47:0] KW_TEXT [NumKw] = '{
		"auto  ", "cin   ", "cout  ", "double", "else  ", "for   ", "if    ",
		"int   ", "return", "string", "while ", "do    ", "try   ", "catch ",
		"throw "
	};
	localparam logic [2:0] KW_LEN [NumKw] = '{
		3'd4, 3'd3, 3'd4, 3'd6, 3'd4, 3'd3, 3'd2, 3'd3, 3'd6, 3'd6, 3'd5,
		3'd2, 3'd3, 3'd5, 3'd5
	};

	// One result item.
	typedef struct packed {
		rtype_t      rtype;
		kind_t       kind;
		logic [7:0]  text;
		logic [30:0] value;
		logic        ovf;
	} rec_t;

	// Scanner state carried between items.
	typedef struct packed {
		mode_t                 mode;
		logic [5:0][7:0]       hold;
		logic [2:0]            ident_count;
		logic [30:0]           accum;
		logic                  ovf_seen;
		logic [3:0]            hex_high;
		logic                  star_seen;
		logic                  halted;
	} scan_state_t;

	function automatic rec_t mk_tok(kind_t k);
		return '{REC_TOKEN, k, 8'd0, 31'd0, 1'b0};
	endfunction

	function automatic rec_t mk_text(logic [7:0] b);
		return '{REC_TEXT, K_END, b, 31'd0, 1'b0};
	endfunction

	function automatic rec_t mk_err();
		return '{REC_ERROR, K_END, 8'd0, 31'd0, 1'b0};
	endfunction

	// Returns {valid, value} of a hex digit.
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'd48)};
		else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'd87)};
		else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'd55)};
		return r;
	endfunction

	// Multiplies by ten and adds a digit; returns {saturated, value}.
	function automatic logic [31:0] add_digit(logic [30:0] acc, logic [7:0] c);
		logic [34:0] t;
		logic [31:0] r;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, 4'(c - 8'd48)};
		if (t > {4'd0, IntMax}) r = {1'b1, IntMax};
		else r = {1'b0, t[30:0]};
		return r;
	endfunction

	// Keyword kind of the held bytes, or K_IDENT.
	function automatic kind_t kw_lookup(logic [5:0][7:0] hold, logic [2:0] cnt);
		kind_t k;
		logic same;
		k = K_IDENT;
		for (int w = NumKw - 1; w >= 0; w--) begin
			same = (KW_LEN[w] == cnt);
			for (int i = 0; i < HoldDepth; i++) begin
				if (3'(i) < cnt && hold[i] != KW_TEXT[w][8*(5-i) +: 8]) same = 1'b0;
			end
			if (same) k = kind_t'(6'(5 + w));
		end
		return k;
	endfunction

endpackage

`default_nettype wire

### rtl/ctok_scan.sv
// Next-state and result logic of the tokenizer for one source byte.
// Depends on ctok_pkg.
`default_nettype none

module ctok_scan import ctok_pkg::*; (
	input  wire scan_state_t cur,
	input  wire logic [7:0]  char_in,
	input  wire logic        end_of_input,
	output scan_state_t      nxt,
	output rec_t [7:0]       recs,
	output logic [3:0]       count
);

	always_comb begin
		logic       rescan;
		logic       dg;
		logic       al;
		logic       sp;
		logic [4:0] hv;
		logic [31:0] ad;
		kind_t      kw;
		logic [7:0] c;
		logic       e;

		c = char_in;
		e = end_of_input;
		nxt = cur;
		recs = '0;
		count = 4'd0;
		rescan = 1'b0;
		dg = !e && c >= "0" && c <= "9";
		al = !e && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
		sp = !e && (c == 8'd32 || (c >= 8'd9 && c <= 8'd13));
		hv = e ? 5'd0 : hex_val(c);
		ad = add_digit(cur.accum, c);
		kw = kw_lookup(cur.hold, cur.ident_count);

		// A terminating byte is scanned again from the idle mode.
		for (int p = 0; p < 2; p++) begin
			if (!cur.halted && (p == 0 || rescan)) begin
				rescan = 1'b0;
				unique case (nxt.mode)
					M_IDLE: begin
						if (e) begin
							recs[count[2:0]] = mk_tok(K_END); count = count + 4'd1;
						end else if (sp) begin
						end else if (al || c == "_") begin
							nxt.hold[0] = c;
							nxt.ident_count = 3'd1;
							nxt.mode = M_IDENT;
						end else if (dg) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							nxt.accum = 31'(c - 8'd48);
							nxt.ovf_seen = 1'b0;
							nxt.mode = M_INT;
						end else begin
							case (c)
								"/": nxt.mode = M_SLASH;
								"\"": nxt.mode = M_STR;
								"!": nxt.mode = M_BANG;
								"=": nxt.mode = M_EQUAL;
								"<": nxt.mode = M_LESS;
								">": nxt.mode = M_GREATER;
								"&": nxt.mode = M_AMP;
								"|": nxt.mode = M_BAR;
								"+": begin recs[count[2:0]] = mk_tok(K_PLUS); count = count + 4'd1; end
								"-": begin recs[count[2:0]] = mk_tok(K_MINUS); count = count + 4'd1; end
								"*": begin recs[count[2:0]] = mk_tok(K_STAR); count = count + 4'd1; end
								"%": begin recs[count[2:0]] = mk_tok(K_PERCENT); count = count + 4'd1; end
								";": begin recs[count[2:0]] = mk_tok(K_SEMI); count = count + 4'd1; end
								",": begin recs[count[2:0]] = mk_tok(K_COMMA); count = count + 4'd1; end
								"(": begin recs[count[2:0]] = mk_tok(K_LPAREN); count = count + 4'd1; end
								")": begin recs[count[2:0]] = mk_tok(K_RPAREN); count = count + 4'd1; end
								"{": begin recs[count[2:0]] = mk_tok(K_LBRACE); count = count + 4'd1; end
								"}": begin recs[count[2:0]] = mk_tok(K_RBRACE); count = count + 4'd1; end
								default: begin
									recs[count[2:0]] = mk_err(); count = count + 4'd1;
									nxt.halted = 1'b1;
								end
							endcase
						end
					end
					M_SLASH: begin
						if (!e && c == "/") nxt.mode = M_LINE;
						else if (!e && c == "*") begin
							nxt.star_seen = 1'b0;
							nxt.mode = M_BLOCK;
						end else begin
							recs[count[2:0]] = mk_tok(K_SLASH); count = count + 4'd1;
							nxt.mode = M_IDLE;
							rescan = 1'b1;
						end
					end
					M_LINE: begin
						if (e) begin
							nxt.mode = M_IDLE;
							rescan = 1'b1;
						end else if (c == 8'd10) nxt.mode = M_IDLE;
					end
					M_BLOCK: begin
						if (e) begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end else if (cur.star_seen && c == "/") begin
							nxt.star_seen = 1'b0;
							nxt.mode = M_IDLE;
						end else nxt.star_seen = (c == "*");
					end
					M_IDENT: begin
						if (al || dg || (!e && c == "_")) begin
							if (cur.ident_count < 3'd6) begin
								nxt.hold[cur.ident_count] = c;
								nxt.ident_count = cur.ident_count + 3'd1;
							end else if (cur.ident_count == 3'd6) begin
								for (int i = 0; i < HoldDepth; i++) recs[i] = mk_text(cur.hold[i]);
								recs[6] = mk_text(c);
								count = 4'd7;
								nxt.ident_count = 3'd7;
							end else begin
								recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							end
						end else begin
							// Finish the identifier: text only when it is no keyword.
							if (cur.ident_count == 3'd7) begin
								recs[count[2:0]] = mk_tok(K_IDENT); count = count + 4'd1;
							end else begin
								if (kw == K_IDENT) begin
									for (int i = 0; i < HoldDepth; i++) begin
										if (3'(i) < cur.ident_count) begin
											recs[count[2:0]] = mk_text(cur.hold[i]);
											count = count + 4'd1;
										end
									end
								end
								recs[count[2:0]] = mk_tok(kw); count = count + 4'd1;
							end
							nxt.ident_count = 3'd0;
							nxt.mode = M_IDLE;
							rescan = 1'b1;
						end
					end
					M_INT: begin
						if (dg) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							nxt.accum = ad[30:0];
							nxt.ovf_seen = cur.ovf_seen | ad[31];
						end else if (!e && c == ".") nxt.mode = M_DOT;
						else if (!e && (c == "e" || c == "E")) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							nxt.mode = M_EXPSTART;
						end else begin
							recs[count[2:0]] = '{REC_TOKEN, K_INT, 8'd0, cur.accum, cur.ovf_seen};
							count = count + 4'd1;
							nxt.accum = 31'd0;
							nxt.ovf_seen = 1'b0;
							nxt.mode = M_IDLE;
							rescan = 1'b1;
						end
					end
					M_DOT: begin
						if (!dg) begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end else begin
							recs[0] = mk_text(".");
							recs[1] = mk_text(c);
							count = 4'd2;
							nxt.mode = M_FRAC;
						end
					end
					M_FRAC, M_EXP: begin
						if (dg) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
						end else if (nxt.mode == M_FRAC && !e && (c == "e" || c == "E")) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							nxt.mode = M_EXPSTART;
						end else begin
							recs[count[2:0]] = mk_tok(K_REAL); count = count + 4'd1;
							nxt.accum = 31'd0;
							nxt.ovf_seen = 1'b0;
							nxt.mode = M_IDLE;
							rescan = 1'b1;
						end
					end
					M_EXPSTART, M_EXPSIGN: begin
						if (nxt.mode == M_EXPSTART && !e && (c == "+" || c == "-")) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							nxt.mode = M_EXPSIGN;
						end else if (dg) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
							nxt.mode = M_EXP;
						end else begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end
					end
					M_STR: begin
						if (e || c < 8'd32) begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end else if (c == "\"") begin
							recs[count[2:0]] = mk_tok(K_STRING); count = count + 4'd1;
							nxt.mode = M_IDLE;
						end else if (c == "\\") nxt.mode = M_ESC;
						else begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
						end
					end
					M_ESC: begin
						nxt.mode = M_STR;
						if (!e && c == "n") begin
							recs[count[2:0]] = mk_text(8'd10); count = count + 4'd1;
						end else if (!e && c == "t") begin
							recs[count[2:0]] = mk_text(8'd9); count = count + 4'd1;
						end else if (!e && (c == "\\" || c == "\"")) begin
							recs[count[2:0]] = mk_text(c); count = count + 4'd1;
						end else if (!e && c == "x") nxt.mode = M_HEX1;
						else begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end
					end
					M_HEX1: begin
						if (!hv[4]) begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end else begin
							nxt.hex_high = hv[3:0];
							nxt.mode = M_HEX2;
						end
					end
					M_HEX2: begin
						if (!hv[4] || {cur.hex_high, hv[3:0]} == 8'd0) begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end else begin
							recs[count[2:0]] = mk_text({cur.hex_high, hv[3:0]});
							count = count + 4'd1;
							nxt.hex_high = 4'd0;
							nxt.mode = M_STR;
						end
					end
					M_BANG, M_EQUAL: begin
						nxt.mode = M_IDLE;
						if (!e && c == "=") begin
							recs[count[2:0]] = mk_tok(cur.mode == M_BANG ? K_NE : K_EQ);
							count = count + 4'd1;
						end else begin
							recs[count[2:0]] = mk_tok(cur.mode == M_BANG ? K_NOT : K_ASSIGN);
							count = count + 4'd1;
							rescan = 1'b1;
						end
					end
					M_LESS, M_GREATER: begin
						nxt.mode = M_IDLE;
						if (!e && c == "=") begin
							recs[count[2:0]] = mk_tok(cur.mode == M_LESS ? K_LE : K_GE);
							count = count + 4'd1;
						end else if (!e && cur.mode == M_LESS && c == "<") begin
							recs[count[2:0]] = mk_tok(K_SHL); count = count + 4'd1;
						end else if (!e && cur.mode == M_GREATER && c == ">") begin
							recs[count[2:0]] = mk_tok(K_SHR); count = count + 4'd1;
						end else begin
							recs[count[2:0]] = mk_tok(cur.mode == M_LESS ? K_LT : K_GT);
							count = count + 4'd1;
							rescan = 1'b1;
						end
					end
					M_AMP, M_BAR: begin
						nxt.mode = M_IDLE;
						if (!e && cur.mode == M_AMP && c == "&") begin
							recs[count[2:0]] = mk_tok(K_ANDAND); count = count + 4'd1;
						end else if (!e && cur.mode == M_BAR && c == "|") begin
							recs[count[2:0]] = mk_tok(K_OROR); count = count + 4'd1;
						end else begin
							recs[count[2:0]] = mk_err(); count = count + 4'd1;
							nxt.halted = 1'b1;
						end
					end
					default: begin
						nxt.mode = M_IDLE;
						rescan = 1'b1;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### rtl/c_like_tokenizer.sv
// An item enters an input register, is scanned from there, and its results are
// registered in the result buffer, which offers them. One item per cycle while each
// item gives at most one result and the receiver takes it; an item with more results
// holds the result buffer until its last result is taken, and the next item is scanned
// in that cycle. Reset clears the scanner to between tokens and empties both registers; a
// lexical error halts the block until reset. Top level; depends on ctok_pkg and ctok_scan.
`default_nettype none

module c_like_tokenizer import ctok_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       record_type,
	output logic [5:0]       token_kind,
	output logic [7:0]       text_byte,
	output logic [30:0]      int_value,
	output logic             int_overflow,
	output logic             last
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eoi_s1;
	scan_state_t state_q;
	scan_state_t state_nxt;
	rec_t [7:0]  recs_nxt;
	logic [3:0]  count_nxt;
	rec_t [7:0]  recs_q;
	logic [3:0]  cnt_q;
	logic [2:0]  rd_q;
	logic        out_fire;
	logic        buf_free;
	logic        s1_fire;
	rec_t        cur_rec;

	// Handshake between the input register and the result buffer.
	assign out_valid = (cnt_q != 4'd0);
	assign out_fire  = out_valid && out_ready;
	assign last      = ({1'b0, rd_q} == cnt_q - 4'd1);
	assign buf_free  = !out_valid || (out_fire && last);
	assign s1_fire   = valid_s1 && buf_free;
	assign in_ready  = !valid_s1 || s1_fire;

	ctok_scan u_scan (
		.cur          (state_q),
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.nxt          (state_nxt),
		.recs         (recs_nxt),
		.count        (count_nxt)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			eoi_s1  <= end_of_input;
		end
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: M_IDLE, default: '0};
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	// Result buffer, drained one item per cycle while the receiver is ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
			rd_q  <= 3'd0;
		end else if (s1_fire) begin
			cnt_q <= count_nxt;
			rd_q  <= 3'd0;
		end else if (out_fire) begin
			if (last) cnt_q <= 4'd0;
			else rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && count_nxt != 4'd0) begin
			recs_q <= recs_nxt;
		end
	end

	// Output fields.
	assign cur_rec      = recs_q[rd_q];
	assign record_type  = cur_rec.rtype;
	assign token_kind   = cur_rec.kind;
	assign text_byte    = cur_rec.text;
	assign int_value    = cur_rec.value;
	assign int_overflow = cur_rec.ovf;

	// Checks.
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, rd_q} < cnt_q) && (cnt_q <= 4'd8))
		else $error("read index beyond buffered results");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted |=> state_q.halted)
		else $error("halt released without reset");
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cur_rec.rtype == REC_ERROR) |-> state_q.halted)
		else $error("error record without halt");
	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !s1_fire)
		else $error("result buffer overwritten while stalled");

endmodule

`default_nettype wire

### verif/tb_c_like_tokenizer.sv
// Self-checking testbench for c_like_tokenizer: feeds source bytes and end marks and
// checks every record against a built-in model of the lexer.
// Depends on rtl/ctok_pkg.sv and rtl/c_like_tokenizer.sv.
`default_nettype none

module tb_c_like_tokenizer import ctok_pkg::*; ();

	typedef struct packed {
		logic [1:0]  rt;
		logic [5:0]  kind;
		logic [7:0]  txt;
		logic [30:0] val;
		logic        ovf;
		logic        lst;
	} token_rec_t;

	localparam int CycleLimit = 300000;
	localparam logic [30:0] SatValue = 31'h7FFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in = 8'd0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  record_type;
	logic [5:0]  token_kind;
	logic [7:0]  text_byte;
	logic [30:0] int_value;
	logic        int_overflow;
	logic        last;

	c_like_tokenizer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_in(char_in), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_ready(out_ready),
		.record_type(record_type), .token_kind(token_kind), .text_byte(text_byte),
		.int_value(int_value), .int_overflow(int_overflow), .last(last)
	);

	always #2 clk = ~clk;

	// Lexer model state.
	mode_t        lex_mode;
	logic [7:0]   held_bytes [6];
	int           held_count;
	logic [30:0]  num_value;
	bit           num_sat;
	logic [3:0]   esc_high;
	bit           saw_star;
	bit           lex_halted;

	token_rec_t   expected_records [$];
	token_rec_t   step_records [$];
	logic [7:0]   source_bytes [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles = 0;
	int items_sent = 0;
	int records_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;

	string keywords [15] = '{"auto", "cin", "cout", "double", "else", "for", "if", "int",
		"return", "string", "while", "do", "try", "catch", "throw"};
	string operators [23] = '{"+", "-", "*", "/", "%", ";", ",", "(", ")", "{", "}", "!",
		"!=", "=", "==", "<", "<=", "<<", ">", ">=", ">>", "&&", "||"};

	// ---------------- Lexer model ----------------

	function automatic bit is_dig(int ch);
		return ch >= "0" && ch <= "9";
	endfunction

	function automatic bit is_letter(int ch);
		return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
	endfunction

	function automatic bit is_ws(int ch);
		return ch == 32 || (ch >= 9 && ch <= 13);
	endfunction

	function automatic int hex_nib(int ch);
		if (is_dig(ch)) return ch - "0";
		if (ch >= "a" && ch <= "f") return ch - "a" + 10;
		if (ch >= "A" && ch <= "F") return ch - "A" + 10;
		return -1;
	endfunction

	function automatic void put_rec(rtype_t rt, kind_t k, logic [7:0] t, logic [30:0] v,
			bit o);
		if (step_records.size() < MaxRes)
			step_records.push_back('{rt, k, t, v, o, 1'b0});
	endfunction

	function automatic void put_tok(kind_t k);
		put_rec(REC_TOKEN, k, 8'd0, 31'd0, 1'b0);
	endfunction

	function automatic void put_text(int b);
		put_rec(REC_TEXT, K_END, 8'(b), 31'd0, 1'b0);
	endfunction

	function automatic void lex_err();
		put_rec(REC_ERROR, K_END, 8'd0, 31'd0, 1'b0);
		lex_halted = 1'b1;
	endfunction

	function automatic void acc_digit(int ch);
		longint t;
		t = longint'(num_value) * 10 + (ch - "0");
		if (t > longint'(SatValue)) begin
			num_value = SatValue;
			num_sat = 1'b1;
		end else begin
			num_value = 31'(t);
		end
	endfunction

	// Keyword kind of the held bytes, or the identifier kind.
	function automatic kind_t find_keyword();
		bit same;
		for (int w = 0; w < 15; w++) begin
			same = (keywords[w].len() == held_count);
			for (int i = 0; i < held_count && same; i++)
				if (keywords[w][i] != held_bytes[i]) same = 1'b0;
			if (same) return kind_t'(5 + w);
		end
		return K_IDENT;
	endfunction

	function automatic void close_ident();
		kind_t k;
		if (held_count >= 7) begin
			put_tok(K_IDENT);
			return;
		end
		k = find_keyword();
		if (k == K_IDENT)
			for (int i = 0; i < held_count; i++) put_text(held_bytes[i]);
		put_tok(k);
	endfunction

	// Scans one symbol (-1 for end of input); returns 1 when it must be scanned again.
	function automatic bit scan_byte(int ch);
		int v;
		case (lex_mode)
			M_IDLE: begin
				if (ch < 0) begin
					put_tok(K_END);
					return 0;
				end
				if (is_ws(ch)) return 0;
				if (is_letter(ch) || ch == "_") begin
					held_bytes[0] = 8'(ch);
					held_count = 1;
					lex_mode = M_IDENT;
					return 0;
				end
				if (is_dig(ch)) begin
					put_text(ch);
					num_value = 0;
					num_sat = 0;
					acc_digit(ch);
					lex_mode = M_INT;
					return 0;
				end
				case (ch)
					"/": lex_mode = M_SLASH;
					"\"": lex_mode = M_STR;
					"+": put_tok(K_PLUS);
					"-": put_tok(K_MINUS);
					"*": put_tok(K_STAR);
					"%": put_tok(K_PERCENT);
					";": put_tok(K_SEMI);
					",": put_tok(K_COMMA);
					"(": put_tok(K_LPAREN);
					")": put_tok(K_RPAREN);
					"{": put_tok(K_LBRACE);
					"}": put_tok(K_RBRACE);
					"!": lex_mode = M_BANG;
					"=": lex_mode = M_EQUAL;
					"<": lex_mode = M_LESS;
					">": lex_mode = M_GREATER;
					"&": lex_mode = M_AMP;
					"|": lex_mode = M_BAR;
					default: lex_err();
				endcase
				return 0;
			end
			M_SLASH: begin
				if (ch == "/") begin
					lex_mode = M_LINE;
					return 0;
				end
				if (ch == "*") begin
					saw_star = 0;
					lex_mode = M_BLOCK;
					return 0;
				end
				put_tok(K_SLASH);
				lex_mode = M_IDLE;
				return 1;
			end
			M_LINE: begin
				if (ch < 0) begin
					lex_mode = M_IDLE;
					return 1;
				end
				if (ch == 10) lex_mode = M_IDLE;
				return 0;
			end
			M_BLOCK: begin
				if (ch < 0) begin
					lex_err();
					return 0;
				end
				if (saw_star && ch == "/") begin
					saw_star = 0;
					lex_mode = M_IDLE;
					return 0;
				end
				saw_star = (ch == "*");
				return 0;
			end
			M_IDENT: begin
				if (is_letter(ch) || is_dig(ch) || ch == "_") begin
					if (held_count < 6) begin
						held_bytes[held_count] = 8'(ch);
						held_count++;
					end else if (held_count == 6) begin
						for (int i = 0; i < 6; i++) put_text(held_bytes[i]);
						put_text(ch);
						held_count = 7;
					end else begin
						put_text(ch);
					end
					return 0;
				end
				close_ident();
				held_count = 0;
				lex_mode = M_IDLE;
				return 1;
			end
			M_INT: begin
				if (is_dig(ch)) begin
					put_text(ch);
					acc_digit(ch);
					return 0;
				end
				if (ch == ".") begin
					lex_mode = M_DOT;
					return 0;
				end
				if (ch == "e" || ch == "E") begin
					put_text(ch);
					lex_mode = M_EXPSTART;
					return 0;
				end
				put_rec(REC_TOKEN, K_INT, 8'd0, num_value, num_sat);
				num_value = 0;
				num_sat = 0;
				lex_mode = M_IDLE;
				return 1;
			end
			M_DOT: begin
				if (!is_dig(ch)) begin
					lex_err();
					return 0;
				end
				put_text(".");
				put_text(ch);
				lex_mode = M_FRAC;
				return 0;
			end
			M_FRAC, M_EXP: begin
				if (is_dig(ch)) begin
					put_text(ch);
					return 0;
				end
				if (lex_mode == M_FRAC && (ch == "e" || ch == "E")) begin
					put_text(ch);
					lex_mode = M_EXPSTART;
					return 0;
				end
				put_tok(K_REAL);
				num_value = 0;
				num_sat = 0;
				lex_mode = M_IDLE;
				return 1;
			end
			M_EXPSTART: begin
				if (ch == "+" || ch == "-") begin
					put_text(ch);
					lex_mode = M_EXPSIGN;
				end else if (is_dig(ch)) begin
					put_text(ch);
					lex_mode = M_EXP;
				end else begin
					lex_err();
				end
				return 0;
			end
			M_EXPSIGN: begin
				if (is_dig(ch)) begin
					put_text(ch);
					lex_mode = M_EXP;
				end else begin
					lex_err();
				end
				return 0;
			end
			M_STR: begin
				if (ch < 32) lex_err();
				else if (ch == "\"") begin
					put_tok(K_STRING);
					lex_mode = M_IDLE;
				end else if (ch == "\\") lex_mode = M_ESC;
				else put_text(ch);
				return 0;
			end
			M_ESC: begin
				lex_mode = M_STR;
				if (ch == "n") put_text(10);
				else if (ch == "t") put_text(9);
				else if (ch == "\\" || ch == "\"") put_text(ch);
				else if (ch == "x") lex_mode = M_HEX1;
				else lex_err();
				return 0;
			end
			M_HEX1: begin
				v = hex_nib(ch);
				if (v < 0) lex_err();
				else begin
					esc_high = 4'(v);
					lex_mode = M_HEX2;
				end
				return 0;
			end
			M_HEX2: begin
				v = hex_nib(ch);
				if (v < 0 || {esc_high, 4'(v)} == 8'd0) lex_err();
				else begin
					put_text({esc_high, 4'(v)});
					esc_high = 0;
					lex_mode = M_STR;
				end
				return 0;
			end
			M_BANG, M_EQUAL: begin
				if (ch == "=") begin
					put_tok(lex_mode == M_BANG ? K_NE : K_EQ);
					lex_mode = M_IDLE;
					return 0;
				end
				put_tok(lex_mode == M_BANG ? K_NOT : K_ASSIGN);
				lex_mode = M_IDLE;
				return 1;
			end
			M_LESS, M_GREATER: begin
				if (ch == "=") put_tok(lex_mode == M_LESS ? K_LE : K_GE);
				else if (lex_mode == M_LESS && ch == "<") put_tok(K_SHL);
				else if (lex_mode == M_GREATER && ch == ">") put_tok(K_SHR);
				else begin
					put_tok(lex_mode == M_LESS ? K_LT : K_GT);
					lex_mode = M_IDLE;
					return 1;
				end
				lex_mode = M_IDLE;
				return 0;
			end
			M_AMP, M_BAR: begin
				if (lex_mode == M_AMP && ch == "&") put_tok(K_ANDAND);
				else if (lex_mode == M_BAR && ch == "|") put_tok(K_OROR);
				else lex_err();
				lex_mode = M_IDLE;
				return 0;
			end
			default: begin
				lex_mode = M_IDLE;
				return 1;
			end
		endcase
	endfunction

	// Works out the records one accepted item causes and queues them.
	function automatic void predict_records(logic [7:0] c, bit eoi);
		int ch;
		ch = eoi ? -1 : int'(c);
		if (lex_halted) return;
		step_records.delete();
		for (int g = 0; g < 4; g++)
			if (!scan_byte(ch) || lex_halted) break;
		if (step_records.size() > 0) step_records[$].lst = 1'b1;
		foreach (step_records[i]) expected_records.push_back(step_records[i]);
	endfunction

	// ---------------- Handshake processes ----------------

	// Receiver: random stalls, or a long hold-off while stall_cycles runs down.
	always @(posedge clk) begin
		if (stall_cycles > 0) begin
			stall_cycles <= stall_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Checks each accepted record against the oldest expected one.
	always @(posedge clk) begin
		token_rec_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{record_type, token_kind, text_byte, int_value, int_overflow, last};
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: type %0d kind %0d text %0h value %0d",
						record_type, token_kind, text_byte, int_value);
			end else begin
				want = expected_records.pop_front();
				records_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected type %0d kind %0d text %0h value %0d ",
							"ovf %0d last %0d, got %0d %0d %0h %0d %0d %0d"},
							want.rt, want.kind, want.txt, want.val, want.ovf, want.lst,
							got.rt, got.kind, got.txt, got.val, got.ovf, got.lst);
				end
			end
		end
	end

	// Run-time limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb_c_like_tokenizer: FAIL");
			$finish;
		end
	end

	// Offers one item, idling first at random; valid stays high after acceptance.
	task automatic send_item(logic [7:0] c, bit eoi);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_records(c, eoi);
		items_sent++;
	endtask

	task automatic send_source();
		foreach (source_bytes[i]) send_item(source_bytes[i], 1'b0);
		source_bytes.delete();
	endtask

	task automatic send_end();
		send_item(8'($urandom), 1'b1);
	endtask

	// Stops offering and waits for every expected record.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ---------------- Source generation ----------------

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] ident_char(bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic void put_digits(int n);
		repeat (n) source_bytes.push_back(8'("0" + $urandom_range(0, 9)));
	endfunction

	function automatic void put_separator();
		int r;
		r = $urandom_range(0, 6);
		source_bytes.push_back(r == 6 ? 8'd32 : 8'(9 + (r % 5)));
	endfunction

	// One well-formed token or comment followed by white space.
	function automatic void put_token();
		int n;
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: begin
				if ($urandom_range(0, 2) == 0) put_str(keywords[$urandom_range(0, 14)]);
				else begin
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12)
						: $urandom_range(1, 6);
					source_bytes.push_back(ident_char(1));
					repeat (n - 1) source_bytes.push_back(ident_char(0));
				end
			end
			1: put_digits($urandom_range(1, 12));
			2: begin
				put_digits($urandom_range(1, 3));
				if ($urandom_range(0, 1)) begin
					put_str(".");
					put_digits($urandom_range(1, 3));
				end
				put_str($urandom_range(0, 1) ? "e" : "E");
				n = $urandom_range(0, 2);
				if (n == 1) put_str("+");
				if (n == 2) put_str("-");
				put_digits($urandom_range(1, 3));
			end
			3: begin
				put_str("\"");
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0: put_str("\\n");
						1: put_str("\\t");
						2: put_str($urandom_range(0, 1) ? "\\\\" : "\\\"");
						3: begin
							b = 8'($urandom_range(1, 255));
							put_str("\\x");
							put_str($sformatf($urandom_range(0, 1) ? "%02x" : "%02X", b));
						end
						default: begin
							do b = 8'($urandom_range(32, 255));
							while (b == "\"" || b == "\\");
							source_bytes.push_back(b);
						end
					endcase
				end
				put_str("\"");
			end
			4, 5: put_str(operators[$urandom_range(0, 22)]);
			6: begin
				put_str("//");
				repeat ($urandom_range(0, 8)) begin
					do b = 8'($urandom); while (b == 8'd10);
					source_bytes.push_back(b);
				end
				source_bytes.push_back(8'd10);
			end
			default: begin
				put_str("/*");
				repeat ($urandom_range(0, 8)) begin
					do b = 8'($urandom); while (b == "/");
					source_bytes.push_back(b);
				end
				put_str("*/");
			end
		endcase
		put_separator();
	endfunction

	// ---------------- Tests ----------------

	// Long identifier, saturating integer, real, escapes, and tokens ended by the next byte.
	task automatic test_directed_tokens();
		send_idle_pct = 12;
		recv_idle_pct = 83;
		put_str("abcdefg/2147483648!=1.5e-3==\"\\x41\\n\"");
		send_source();
		send_end();
		wait_drained();
	endtask

	// All keywords and all operators but /, != and ==, packed so each ends the prior token.
	task automatic test_keywords_ops();
		send_idle_pct = 83;
		recv_idle_pct = 12;
		put_str("<=auto<<cin>=cout>>double&&else||for+if-int*return%string;");
		put_str("while,do(try)catch{throw}x!y=z<w>v//c");
		send_source();
		send_end();
		wait_drained();
	endtask

	// Random well-formed source under one idle setting.
	task automatic test_random_source(int snd_pct, int rcv_pct, int n_items);
		int stop_at;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			put_token();
			send_source();
			if ($urandom_range(0, 9) == 0) send_end();
		end
		send_end();
		wait_drained();
	endtask

	// A long identifier while the receiver holds off, so the block fills and stalls.
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_cycles = 300;
		put_str("abcdefghi ");
		send_source();
		send_end();
		wait_drained();
	endtask

	// One lexical error, then the block must stay silent.
	task automatic test_error_halt();
		case ($urandom_range(0, 9))
			0: put_str("@");
			1: put_str("&x");
			2: put_str("|x");
			3: put_str("1.x");
			4: put_str("1e;");
			5: put_str("\"ab\n");
			6: put_str("\"\\q");
			7: put_str("\"\\xg1");
			8: put_str("\"\\x00");
			default: put_str("/*ab");
		endcase
		send_source();
		send_end();
		put_str("ab 1");
		send_source();
		send_end();
		wait_drained();
		repeat (20) @(posedge clk);
	endtask

	initial begin
		lex_mode = M_IDLE;
		held_count = 0;
		num_value = 0;
		num_sat = 0;
		esc_high = 0;
		saw_star = 0;
		lex_halted = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_tokens();
		test_keywords_ops();
		test_random_source(0, 0, 6);
		test_output_stall();
		test_error_halt();

		$display("Covered every keyword and operator, number and string forms, comments,");
		$display("random source, a long output stall and one lexical error: %0d items sent,",
			items_sent);
		$display("%0d records checked, %0d mismatches.", records_checked, mismatches);
		if (mismatches == 0 && expected_records.size() == 0) begin
			$display("tb_c_like_tokenizer: PASS");
		end else begin
			$display("tb_c_like_tokenizer: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
